// ===== hw/rtl/ifdc_pkg.sv =====
// shared constants and types for the information frame deframer and checker
`timescale 1ns / 1ps

package ifdc_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] STUFF_MASK = 8'h20;
  localparam logic [7:0] CTRL_SEQ0  = 8'h00;
  localparam logic [7:0] CTRL_SEQ1  = 8'h80;
  localparam logic [7:0] RR_SEQ0    = 8'hAA;
  localparam logic [7:0] RR_SEQ1    = 8'hAB;
  localparam logic [7:0] REJ_SEQ0   = 8'h54;
  localparam logic [7:0] REJ_SEQ1   = 8'h55;

  localparam logic [7:0] ADDR_RESET       = 8'h03;
  localparam logic [7:0] REPLY_ADDR_RESET = 8'h01;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  // configuration register indexes
  localparam logic REG_EXPECTED_ADDRESS = 1'b0;
  localparam logic REG_REPLY_ADDRESS    = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_DUP    = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_FLAG = 6'b000010,
    PH_ADDR = 6'b000100,
    PH_CTRL = 6'b001000,
    PH_DATA = 6'b010000,
    PH_ESC  = 6'b100000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  reply_control;
    logic [7:0]  reply_check;
    logic [15:0] payload_length;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/info_frame_deframer_checker.sv =====
// top level: byte-stuffed information frame deframer with xor header and frame checks
`timescale 1ns / 1ps
//
// usage
//   input channel: rx_byte with in_valid / in_stall, one raw line byte per transfer.
//   output channel: kind, data_byte, reply_control, reply_check, payload_length, last
//   with out_valid / out_stall. payload bytes come out one byte late as kind 0;
//   the closing flag gives one verdict transfer (last = 1).
//   config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
//   the expected address, index 1 the reply address. cfg_ready is always high.
//   throughput: one byte per cycle while in_stall is low; the parser state is updated
//   in the same cycle the byte is taken, and the result lands in the output register
//   or, while a result waits there, in the skid entry.
//   a two-entry output buffer (output register plus skid entry) lets the block take
//   bytes while a result waits; in_stall rises only when both entries are full.
//   reset clears the parser to hunting for a flag, expected sequence to zero, the
//   output buffer to empty, and the addresses to 0x03 and 0x01.
//   while out_stall is held, results stay on the output unchanged.
//
module info_frame_deframer_checker
  import ifdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [7:0]  reply_control,
  output logic [7:0]  reply_check,
  output logic [15:0] payload_length,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0]  expected_address;
  logic [7:0]  reply_address;
  phase_t      phase, phase_next;
  logic        expected_seq, expected_seq_next;
  logic        frame_seq, frame_seq_next;
  logic        held_valid, held_valid_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [7:0]  running_check, running_check_next;
  logic [15:0] byte_count, byte_count_next;

  result_t     out_reg, skid_reg, res;
  logic        skid_valid;
  logic        has_res;
  logic        take_en;
  logic [7:0]  take_byte;
  logic        in_fire;
  logic        good;
  logic [7:0]  rctrl;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_address <= ADDR_RESET;
      reply_address    <= REPLY_ADDR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXPECTED_ADDRESS: expected_address <= cfg_data;
        REG_REPLY_ADDRESS:    reply_address    <= cfg_data;
        default: ;
      endcase
    end
  end

  // parser next state and the result of the current byte
  always_comb begin
    phase_next         = phase;
    expected_seq_next  = expected_seq;
    frame_seq_next     = frame_seq;
    held_valid_next    = held_valid;
    held_byte_next     = held_byte;
    running_check_next = running_check;
    byte_count_next    = byte_count;
    has_res            = 1'b0;
    res                = '0;
    take_en            = 1'b0;
    take_byte          = rx_byte;
    good               = held_valid && (held_byte == running_check);
    rctrl              = good ? (expected_seq ? RR_SEQ1 : RR_SEQ0)
                              : (expected_seq ? REJ_SEQ1 : REJ_SEQ0);

    unique case (phase)
      PH_FLAG: begin
        if (rx_byte == expected_address) phase_next = PH_ADDR;
        else if (rx_byte != FLAG_BYTE)   phase_next = PH_HUNT;
      end
      PH_ADDR: begin
        if (rx_byte == CTRL_SEQ0 || rx_byte == CTRL_SEQ1) begin
          frame_seq_next = (rx_byte == CTRL_SEQ1);
          phase_next     = PH_CTRL;
        end else if (rx_byte == FLAG_BYTE) begin
          phase_next = PH_FLAG;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_CTRL: begin
        if (rx_byte == ((frame_seq ? CTRL_SEQ1 : CTRL_SEQ0) ^ expected_address)) begin
          phase_next         = PH_DATA;
          held_valid_next    = 1'b0;
          held_byte_next     = '0;
          running_check_next = '0;
          byte_count_next    = '0;
        end else if (rx_byte == FLAG_BYTE) begin
          phase_next = PH_FLAG;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (rx_byte == ESC_BYTE) begin
          phase_next = PH_ESC;
        end else if (rx_byte == FLAG_BYTE) begin
          // closing flag: verdict uses the sequence bit before any toggle
          has_res = 1'b1;
          if (good && (frame_seq == expected_seq)) begin
            res.kind          = KIND_NEW;
            expected_seq_next = !expected_seq;
          end else if (good) begin
            res.kind = KIND_DUP;
          end else begin
            res.kind = KIND_REJECT;
          end
          res.reply_control  = rctrl;
          res.reply_check    = reply_address ^ rctrl;
          res.payload_length = held_valid ? byte_count : '0;
          res.last           = 1'b1;
          phase_next         = PH_HUNT;
          held_valid_next    = 1'b0;
          held_byte_next     = '0;
          running_check_next = '0;
          byte_count_next    = '0;
        end else begin
          take_en = 1'b1;
        end
      end
      PH_ESC: begin
        phase_next = PH_DATA;
        take_en    = 1'b1;
        take_byte  = rx_byte ^ STUFF_MASK;
      end
      default: begin
        phase_next = (rx_byte == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
      end
    endcase

    // release the held byte and hold the new one
    if (take_en) begin
      if (held_valid) begin
        has_res            = 1'b1;
        res.kind           = KIND_DATA;
        res.data_byte      = held_byte;
        running_check_next = running_check ^ held_byte;
        if (byte_count != COUNT_MAX) byte_count_next = byte_count + 16'd1;
      end
      held_byte_next  = take_byte;
      held_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      expected_seq <= 1'b0;
      frame_seq    <= 1'b0;
      held_valid   <= 1'b0;
      held_byte    <= '0;
      running_check <= '0;
      byte_count   <= '0;
    end else if (in_fire) begin
      phase         <= phase_next;
      expected_seq  <= expected_seq_next;
      frame_seq     <= frame_seq_next;
      held_valid    <= held_valid_next;
      held_byte     <= held_byte_next;
      running_check <= running_check_next;
      byte_count    <= byte_count_next;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end else if (in_fire && has_res) begin
          out_reg <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid) begin
        if (in_fire && has_res) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end
      end else if (in_fire && has_res) begin
        skid_reg   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign kind           = out_reg.kind;
  assign data_byte      = out_reg.data_byte;
  assign reply_control  = out_reg.reply_control;
  assign reply_check    = out_reg.reply_check;
  assign payload_length = out_reg.payload_length;
  assign last           = out_reg.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  a_data_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reg.last |-> out_reg.kind == KIND_DATA && out_reg.reply_control == 8'h00)
    else $error("payload transfer carries verdict fields");

  a_new_is_rr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.kind == KIND_NEW |->
      out_reg.reply_control == RR_SEQ0 || out_reg.reply_control == RR_SEQ1)
    else $error("accepted frame without receiver-ready reply");

  a_reject_is_rej: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.kind == KIND_REJECT |->
      out_reg.reply_control == REJ_SEQ0 || out_reg.reply_control == REJ_SEQ1)
    else $error("rejected frame without reject reply");

endmodule

// ===== tb/sv/tb_info_frame_deframer_checker.sv =====
// self-checking testbench for the information frame deframer and checker
`timescale 1ns / 1ps

module tb_info_frame_deframer_checker;
  import ifdc_pkg::*;

  typedef enum {CHECK_GOOD, CHECK_BAD, CHECK_NONE} check_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  reply_control;
  logic [7:0]  reply_check;
  logic [15:0] payload_length;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_EXPECTED_ADDRESS;
  logic [7:0]  cfg_data = 8'h00;

  info_frame_deframer_checker dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data_byte      (data_byte),
    .reply_control  (reply_control),
    .reply_check    (reply_check),
    .payload_length (payload_length),
    .last           (last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0] line_bytes [$];
  result_t    results_due [$];
  int         idle_pct = 23;
  int         mismatches = 0;
  bit         in_taken = 1'b0;

  // predictor state and its copy of the registers
  phase_t      rx_phase;
  logic [7:0]  match_addr;
  logic [7:0]  answer_addr;
  logic        want_seq;
  logic        frame_seq;
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic [7:0]  sum_check;
  logic [15:0] data_count;

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t: %s", $time, what);
  endtask

  // releases the held byte as payload and holds the new one
  function automatic bit take_byte(input logic [7:0] b, inout result_t r);
    bit made;
    made = hold_valid;
    if (hold_valid) begin
      r.kind = KIND_DATA;
      r.data_byte = hold_byte;
      sum_check = sum_check ^ hold_byte;
      if (data_count != COUNT_MAX) data_count = data_count + 16'd1;
    end
    hold_byte = b;
    hold_valid = 1'b1;
    return made;
  endfunction

  function automatic bit step_deframer(input logic [7:0] b, output result_t r);
    bit made;
    logic [7:0] ctrl;
    made = 1'b0;
    r = '0;
    case (rx_phase)
      PH_FLAG: begin
        // address match wins over a repeated flag
        if (b == match_addr) rx_phase = PH_ADDR;
        else if (b != FLAG_BYTE) rx_phase = PH_HUNT;
      end
      PH_ADDR: begin
        if (b == CTRL_SEQ0 || b == CTRL_SEQ1) begin
          frame_seq = (b == CTRL_SEQ1);
          rx_phase = PH_CTRL;
        end else if (b == FLAG_BYTE) begin
          rx_phase = PH_FLAG;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_CTRL: begin
        ctrl = frame_seq ? CTRL_SEQ1 : CTRL_SEQ0;
        if (b == (ctrl ^ match_addr)) begin
          rx_phase = PH_DATA;
          hold_valid = 1'b0;
          hold_byte = 8'h00;
          sum_check = 8'h00;
          data_count = 16'd0;
        end else if (b == FLAG_BYTE) begin
          rx_phase = PH_FLAG;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (b == ESC_BYTE) begin
          rx_phase = PH_ESC;
        end else if (b == FLAG_BYTE) begin
          // closing flag: verdict from the held check byte
          made = 1'b1;
          r.payload_length = hold_valid ? data_count : 16'd0;
          if (hold_valid && hold_byte == sum_check) begin
            ctrl = want_seq ? RR_SEQ1 : RR_SEQ0;
            if (frame_seq == want_seq) begin
              r.kind = KIND_NEW;
              want_seq = !want_seq;
            end else begin
              r.kind = KIND_DUP;
            end
          end else begin
            r.kind = KIND_REJECT;
            ctrl = want_seq ? REJ_SEQ1 : REJ_SEQ0;
          end
          r.reply_control = ctrl;
          r.reply_check = answer_addr ^ ctrl;
          r.last = 1'b1;
          rx_phase = PH_HUNT;
          hold_valid = 1'b0;
          hold_byte = 8'h00;
          sum_check = 8'h00;
          data_count = 16'd0;
        end else begin
          made = take_byte(b, r);
        end
      end
      PH_ESC: begin
        rx_phase = PH_DATA;
        made = take_byte(b ^ STUFF_MASK, r);
      end
      default: rx_phase = (b == FLAG_BYTE) ? PH_FLAG : PH_HUNT;
    endcase
    return made;
  endfunction

  // monitor: output check first, then prediction for the byte taken at this edge
  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    if (rst) begin
      rx_phase = PH_HUNT;
      match_addr = ADDR_RESET;
      answer_addr = REPLY_ADDR_RESET;
      want_seq = 1'b0;
      frame_seq = 1'b0;
      hold_valid = 1'b0;
      hold_byte = 8'h00;
      sum_check = 8'h00;
      data_count = 16'd0;
      in_taken = 1'b0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected, kind %0d", kind));
        end else begin
          want = results_due.pop_front();
          if (kind !== want.kind)
            note_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
          if (data_byte !== want.data_byte)
            note_mismatch($sformatf("data_byte %h, want %h", data_byte, want.data_byte));
          if (reply_control !== want.reply_control)
            note_mismatch($sformatf("reply_control %h, want %h", reply_control,
                                    want.reply_control));
          if (reply_check !== want.reply_check)
            note_mismatch($sformatf("reply_check %h, want %h", reply_check,
                                    want.reply_check));
          if (payload_length !== want.payload_length)
            note_mismatch($sformatf("payload_length %0d, want %0d", payload_length,
                                    want.payload_length));
          if (last !== want.last)
            note_mismatch($sformatf("last %b, want %b", last, want.last));
        end
      end
      in_taken = in_valid && !in_stall;
      if (in_taken && step_deframer(rx_byte, fresh)) results_due.push_back(fresh);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_EXPECTED_ADDRESS) match_addr = cfg_data;
        else answer_addr = cfg_data;
      end
    end
  end

  // driver: a new byte only after the previous transfer, payload held while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (line_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= line_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic push_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(b ^ STUFF_MASK);
    end else begin
      line_bytes.push_back(b);
    end
  endtask

  // raw byte leaning towards values that steer the parser
  function automatic logic [7:0] steer_byte();
    int r = $urandom_range(99);
    if (r < 20) return FLAG_BYTE;
    if (r < 30) return ESC_BYTE;
    if (r < 40) return match_addr;
    if (r < 50) return $urandom_range(1) ? CTRL_SEQ1 : CTRL_SEQ0;
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_frame(input logic [7:0] addr, input bit seq, input int len,
                             input check_mode_t mode);
    logic [7:0] ctrl;
    logic [7:0] sum;
    logic [7:0] b;
    int r;
    ctrl = seq ? CTRL_SEQ1 : CTRL_SEQ0;
    sum = 8'h00;
    line_bytes.push_back(FLAG_BYTE);
    line_bytes.push_back(addr);
    line_bytes.push_back(ctrl);
    line_bytes.push_back(addr ^ ctrl);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      b = (r < 8) ? FLAG_BYTE : (r < 16) ? ESC_BYTE : 8'($urandom_range(255));
      sum = sum ^ b;
      push_stuffed(b);
    end
    if (mode == CHECK_GOOD) push_stuffed(sum);
    else if (mode == CHECK_BAD) push_stuffed(sum ^ (8'h01 << $urandom_range(7)));
    line_bytes.push_back(FLAG_BYTE);
  endtask

  task automatic queue_random_unit();
    int r = $urandom_range(99);
    int lr;
    int len;
    int stop;
    logic [7:0] addr;
    logic [7:0] ctrl;
    check_mode_t mode;
    if (r < 72) begin
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) line_bytes.push_back(FLAG_BYTE);
      lr = $urandom_range(99);
      len = (lr < 70) ? $urandom_range(0, 6) :
            (lr < 95) ? $urandom_range(7, 40) : $urandom_range(41, 200);
      addr = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : match_addr;
      lr = $urandom_range(99);
      mode = (lr < 80) ? CHECK_GOOD : (lr < 92) ? CHECK_BAD : CHECK_NONE;
      queue_frame(addr, 1'($urandom_range(1)), len, mode);
    end else if (r < 86) begin
      // header cut short or followed by unstuffed junk
      ctrl = $urandom_range(1) ? CTRL_SEQ1 : CTRL_SEQ0;
      stop = $urandom_range(2);
      line_bytes.push_back(FLAG_BYTE);
      line_bytes.push_back(match_addr);
      if (stop > 0) line_bytes.push_back(ctrl);
      if (stop > 1) line_bytes.push_back(match_addr ^ ctrl);
      repeat ($urandom_range(1, 8)) line_bytes.push_back(steer_byte());
      line_bytes.push_back(FLAG_BYTE);
    end else begin
      repeat ($urandom_range(1, 8)) line_bytes.push_back(steer_byte());
    end
  endtask

  // sender holds off until every result is in, then a short settle
  task automatic wait_quiet();
    while (line_bytes.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(input logic [7:0] addr, input logic [7:0] reply);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_EXPECTED_ADDRESS;
    cfg_data <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_REPLY_ADDRESS;
    cfg_data <= reply;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening [0:29];
    logic [7:0] phase_addr [0:5];
    logic [7:0] phase_reply [0:5];
    // repeated flags and an empty frame; check byte only; escaped flag and
    // escape in a duplicate; flag inside the header with a bad lone check byte
    opening = '{8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h7E,
                8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h7E,
                8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h03, 8'h7E,
                8'h7E, 8'h03, 8'h7E, 8'h03, 8'h80, 8'h83, 8'hFF, 8'h7E};
    phase_addr  = '{8'h00, 8'hFF, 8'h7E, 8'h7D, 8'h00, 8'h03};
    phase_reply = '{8'hFF, 8'h00, 8'h7D, 8'h7E, 8'h00, 8'h01};
    phase_addr[4]  = 8'($urandom_range(255));
    phase_reply[4] = 8'($urandom_range(255));

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (opening[i]) line_bytes.push_back(opening[i]);
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      set_registers(phase_addr[p], phase_reply[p]);
      idle_pct = (p == 2) ? 0 : 23;
      while (line_bytes.size() < 320) queue_random_unit();
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("info_frame_deframer_checker verification clean");
    end else begin
      $display("info_frame_deframer_checker verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("info_frame_deframer_checker verification failed");
    $finish;
  end

endmodule
